[src/qts_pkg.sv]
// ----------------------------------------------------------------------------
// qts_pkg
// Shared types and constants for the quoted token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package qts_pkg;

    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_OCT = 2'd1;
    localparam logic [1:0] STATUS_NO_TOK  = 2'd2;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_SKIP,
        MODE_TOKEN,
        MODE_ESC,
        MODE_OCT1,
        MODE_OCT2
    } mode_t;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_DQUOTE,
        CLS_SQUOTE,
        CLS_BSLASH,
        CLS_OCTAL,
        CLS_OTHER,
        CLS_EOD
    } class_t;

    typedef struct packed {
        logic [7:0] data;
        class_t     cls;
    } item_t;

endpackage

`default_nettype wire

[src/qts_front.sv]
// ----------------------------------------------------------------------------
// qts_front
// Classifies each incoming byte for the scanner state machine.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_front (
    input  wire logic         [7:0] data_byte,
    input  wire logic               end_of_data,
    output qts_pkg::item_t          item
);

    qts_pkg::class_t cls;

    always_comb
    begin
        if (end_of_data) begin
            cls = qts_pkg::CLS_EOD;
        end else if (data_byte == qts_pkg::CH_SPACE || data_byte == qts_pkg::CH_TAB ||
                     data_byte == qts_pkg::CH_CR || data_byte == qts_pkg::CH_LF) begin
            cls = qts_pkg::CLS_SPACE;
        end else if (data_byte == qts_pkg::CH_DQUOTE) begin
            cls = qts_pkg::CLS_DQUOTE;
        end else if (data_byte == qts_pkg::CH_SQUOTE) begin
            cls = qts_pkg::CLS_SQUOTE;
        end else if (data_byte == qts_pkg::CH_BACKSLASH) begin
            cls = qts_pkg::CLS_BSLASH;
        end else if (data_byte >= qts_pkg::CH_ZERO && data_byte <= qts_pkg::CH_SEVEN) begin
            cls = qts_pkg::CLS_OCTAL;
        end else begin
            cls = qts_pkg::CLS_OTHER;
        end
    end

    assign item.data = data_byte;
    assign item.cls  = cls;

endmodule

`default_nettype wire

[src/qts_queue.sv]
// ----------------------------------------------------------------------------
// qts_queue
// Short register queue between the classifier and the scanner back end.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  qts_pkg::item_t      push_item,
    output logic                full,
    input  wire logic           pop,
    output qts_pkg::item_t      pop_item,
    output logic                not_empty
);

    qts_pkg::item_t                   entry_reg [qts_pkg::QUEUE_DEPTH];
    logic [qts_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [qts_pkg::QUEUE_AW-1:0]     wr_ptr_next;
    logic [qts_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [qts_pkg::QUEUE_AW-1:0]     rd_ptr_next;
    logic [qts_pkg::QUEUE_CW-1:0]     count_reg;
    logic [qts_pkg::QUEUE_CW-1:0]     count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full      = (count_reg == qts_pkg::QUEUE_CW'(qts_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == qts_pkg::QUEUE_AW'(qts_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == qts_pkg::QUEUE_AW'(qts_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[src/qts_back.sv]
// ----------------------------------------------------------------------------
// qts_back
// Scanner state machine that turns classified bytes into token results.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  qts_pkg::item_t      item,
    input  wire logic           item_valid,
    output logic                item_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic          [7:0] out_byte,
    output logic                byte_valid,
    output logic                token_last,
    output logic          [1:0] status
);

    qts_pkg::mode_t mode_reg;
    qts_pkg::mode_t mode_next;
    logic           quote_kind_reg;
    logic           quote_kind_next;
    logic           in_quote_reg;
    logic           in_quote_next;
    logic [5:0]     accum_reg;
    logic [5:0]     accum_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [7:0]     out_byte_reg;
    logic [7:0]     out_byte_next;
    logic           byte_valid_reg;
    logic           byte_valid_next;
    logic           token_last_reg;
    logic           token_last_next;
    logic [1:0]     status_reg;
    logic [1:0]     status_next;
    logic           slot_free;
    logic           emit;
    logic           close_quote;

    assign slot_free   = !out_valid_reg || out_ready;
    assign item_pop    = item_valid && slot_free;
    assign close_quote = quote_kind_reg ? (item.cls == qts_pkg::CLS_SQUOTE) :
                                          (item.cls == qts_pkg::CLS_DQUOTE);

    always_comb
    begin
        mode_next       = mode_reg;
        quote_kind_next = quote_kind_reg;
        in_quote_next   = in_quote_reg;
        accum_next      = accum_reg;
        emit            = 1'b0;
        out_byte_next   = 8'h00;
        byte_valid_next = 1'b0;
        token_last_next = 1'b0;
        status_next     = qts_pkg::STATUS_OK;

        if (item_pop) begin
            if (item.cls == qts_pkg::CLS_EOD) begin
                emit          = 1'b1;
                mode_next     = qts_pkg::MODE_SKIP;
                in_quote_next = 1'b0;
                accum_next    = '0;
                unique case (mode_reg)
                    qts_pkg::MODE_SKIP:
                    begin
                        status_next = qts_pkg::STATUS_NO_TOK;
                    end
                    qts_pkg::MODE_OCT1, qts_pkg::MODE_OCT2:
                    begin
                        status_next = qts_pkg::STATUS_BAD_OCT;
                    end
                    default:
                    begin
                        token_last_next = 1'b1;
                    end
                endcase
            end else begin
                unique case (mode_reg)
                    qts_pkg::MODE_SKIP:
                    begin
                        if (item.cls == qts_pkg::CLS_DQUOTE ||
                            item.cls == qts_pkg::CLS_SQUOTE) begin
                            in_quote_next   = 1'b1;
                            quote_kind_next = (item.cls == qts_pkg::CLS_SQUOTE);
                            mode_next       = qts_pkg::MODE_TOKEN;
                        end else if (item.cls == qts_pkg::CLS_BSLASH) begin
                            in_quote_next = 1'b0;
                            mode_next     = qts_pkg::MODE_ESC;
                        end else if (item.cls != qts_pkg::CLS_SPACE) begin
                            in_quote_next   = 1'b0;
                            mode_next       = qts_pkg::MODE_TOKEN;
                            emit            = 1'b1;
                            out_byte_next   = item.data;
                            byte_valid_next = 1'b1;
                        end
                    end
                    qts_pkg::MODE_TOKEN:
                    begin
                        if (in_quote_reg ? close_quote : (item.cls == qts_pkg::CLS_SPACE)) begin
                            mode_next       = qts_pkg::MODE_SKIP;
                            in_quote_next   = 1'b0;
                            accum_next      = '0;
                            emit            = 1'b1;
                            token_last_next = 1'b1;
                        end else if (item.cls == qts_pkg::CLS_BSLASH) begin
                            mode_next = qts_pkg::MODE_ESC;
                        end else begin
                            emit            = 1'b1;
                            out_byte_next   = item.data;
                            byte_valid_next = 1'b1;
                        end
                    end
                    qts_pkg::MODE_ESC:
                    begin
                        if (item.cls == qts_pkg::CLS_OCTAL) begin
                            accum_next = {3'b000, item.data[2:0]};
                            mode_next  = qts_pkg::MODE_OCT1;
                        end else begin
                            mode_next       = qts_pkg::MODE_TOKEN;
                            emit            = 1'b1;
                            out_byte_next   = item.data;
                            byte_valid_next = 1'b1;
                        end
                    end
                    qts_pkg::MODE_OCT1, qts_pkg::MODE_OCT2:
                    begin
                        if (item.cls != qts_pkg::CLS_OCTAL) begin
                            mode_next     = qts_pkg::MODE_SKIP;
                            in_quote_next = 1'b0;
                            accum_next    = '0;
                            emit          = 1'b1;
                            status_next   = qts_pkg::STATUS_BAD_OCT;
                        end else if (mode_reg == qts_pkg::MODE_OCT1) begin
                            accum_next = {accum_reg[2:0], item.data[2:0]};
                            mode_next  = qts_pkg::MODE_OCT2;
                        end else begin
                            accum_next      = '0;
                            mode_next       = qts_pkg::MODE_TOKEN;
                            emit            = 1'b1;
                            out_byte_next   = {accum_reg[4:0], item.data[2:0]};
                            byte_valid_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next     = qts_pkg::MODE_SKIP;
                        in_quote_next = 1'b0;
                        accum_next    = '0;
                    end
                endcase
            end
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= qts_pkg::MODE_SKIP;
            quote_kind_reg <= 1'b0;
            in_quote_reg   <= 1'b0;
            accum_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            quote_kind_reg <= quote_kind_next;
            in_quote_reg   <= in_quote_next;
            accum_reg      <= accum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            out_byte_reg   <= out_byte_next;
            byte_valid_reg <= byte_valid_next;
            token_last_reg <= token_last_next;
            status_reg     <= status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign token_last = token_last_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

[src/quoted_token_scanner_core.sv]
// ----------------------------------------------------------------------------
// quoted_token_scanner_core
// Splits a byte stream into whitespace or quote delimited tokens with escapes.
// ----------------------------------------------------------------------------
// Throughput is one byte per cycle while the output is not stalled; the scanner state machine updates once per byte.
// A byte is held in the queue, and the result it causes is registered at the scanner output.
// A two-entry queue decouples input transfers from output stalls.
// Reset returns the scanner to skipping whitespace with an empty queue and output.
`default_nettype none

module quoted_token_scanner_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] out_byte,
    output logic            byte_valid,
    output logic            token_last,
    output logic      [1:0] status
);

    qts_pkg::item_t in_item;
    qts_pkg::item_t head_item;
    logic           queue_full;
    logic           queue_not_empty;
    logic           queue_pop;

    qts_front u_front (
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .item        (in_item)
    );

    qts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_item (in_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_item  (head_item),
        .not_empty (queue_not_empty)
    );

    assign in_ready = !queue_full;

    qts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (head_item),
        .item_valid (queue_not_empty),
        .item_pop   (queue_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .token_last (token_last),
        .status     (status)
    );

endmodule

`default_nettype wire
